@@ rtl/llma_pkg.sv @@
// ----------------------------------------------------------------------------
// llma_pkg
// shared types and constants for the least loaded machine assigner
// ----------------------------------------------------------------------------
package llma_pkg;

	localparam int DEF_NUM_MACHINES = 16;
	localparam int LOAD_W           = 16;
	localparam int TOTAL_W          = 32;
	// stored machine number, wide enough for the largest heap
	localparam int MACHINE_W        = 8;
	// machine number as reported on the result port
	localparam int NUM_W            = 4;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef struct packed {
		logic [MACHINE_W-1:0] machine;
		logic [TOTAL_W-1:0]   total;
	} slot_t;

	typedef struct packed {
		logic [NUM_W-1:0]   machine_number;
		logic [TOTAL_W-1:0] machine_total;
	} result_t;

endpackage

@@ rtl/least_loaded_machine_assigner_top.sv @@
// ----------------------------------------------------------------------------
// least_loaded_machine_assigner_top
// greedy job assignment to the least loaded machine over a min-heap memory
// ----------------------------------------------------------------------------
// Each request on the input channel (in_valid / in_stall, job_size) carries
// one job load. The job goes to the machine with the smallest accumulated
// load (ties go to the slot nearer the heap root); the result channel
// (out_valid / out_stall, machine_number, machine_total) returns that machine
// and its new total, saturating at all ones.
// After acceptance the ROOT state adds the load to the root total, and the
// result waits in the EMIT state until the output register takes it. The
// block then sifts the updated root down the heap, one level at a time
// (child read state, then compare and write-back state).
// in_stall is high from acceptance until the sift finishes.
// If out_stall holds a previous result, the new one waits in the sifter and
// the sift pauses until the output register frees up.
// Reset: all totals are zero and slot k holds machine k; no clearing pass
// is needed, the block accepts a request in the first cycle after reset.
// ----------------------------------------------------------------------------
module least_loaded_machine_assigner_top #(
	parameter int NUM_MACHINES = llma_pkg::DEF_NUM_MACHINES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [llma_pkg::LOAD_W-1:0]   job_size,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [llma_pkg::NUM_W-1:0]    machine_number,
	output logic [llma_pkg::TOTAL_W-1:0]  machine_total
);
	import llma_pkg::*;

	localparam int IDX_W = $clog2(NUM_MACHINES);

	logic             emit_valid;
	logic             emit_ready;
	result_t          emit_res;
	logic [IDX_W-1:0] rd_a_addr;
	logic [IDX_W-1:0] rd_b_addr;
	slot_t            rd_a_slot;
	slot_t            rd_b_slot;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	slot_t            wr_slot;

	logic             out_valid_q;
	result_t          out_res_q;

	llma_heap_mem #(
		.NUM_MACHINES (NUM_MACHINES),
		.IDX_W        (IDX_W)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.rd_a_slot (rd_a_slot),
		.rd_b_slot (rd_b_slot),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_slot   (wr_slot)
	);

	llma_sifter #(
		.NUM_MACHINES (NUM_MACHINES),
		.IDX_W        (IDX_W)
	) u_sifter (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.job_size   (job_size),
		.emit_valid (emit_valid),
		.emit_ready (emit_ready),
		.emit_res   (emit_res),
		.rd_a_addr  (rd_a_addr),
		.rd_b_addr  (rd_b_addr),
		.rd_a_slot  (rd_a_slot),
		.rd_b_slot  (rd_b_slot),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_slot    (wr_slot)
	);

	// output register frees when empty or when its result is taken
	assign emit_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_ready) begin
			out_valid_q <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ready && emit_valid) begin
			out_res_q <= emit_res;
		end
	end

	assign out_valid      = out_valid_q;
	assign machine_number = out_res_q.machine_number;
	assign machine_total  = out_res_q.machine_total;

endmodule

@@ rtl/llma_heap_mem.sv @@
// ----------------------------------------------------------------------------
// llma_heap_mem
// heap slot memory: two registered read ports, one write port; a slot never
// written reads as its reset contents (machine = slot index, total = 0)
// ----------------------------------------------------------------------------
module llma_heap_mem #(
	parameter int NUM_MACHINES = llma_pkg::DEF_NUM_MACHINES,
	parameter int IDX_W        = $clog2(NUM_MACHINES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [IDX_W-1:0]   rd_a_addr,
	input  logic [IDX_W-1:0]   rd_b_addr,
	output llma_pkg::slot_t    rd_a_slot,
	output llma_pkg::slot_t    rd_b_slot,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  llma_pkg::slot_t    wr_slot
);
	import llma_pkg::*;

	slot_t                   mem [NUM_MACHINES];
	logic [NUM_MACHINES-1:0] written_q;

	slot_t            rd_a_data_s1;
	slot_t            rd_b_data_s1;
	logic             rd_a_written_s1;
	logic             rd_b_written_s1;
	logic [IDX_W-1:0] rd_a_addr_s1;
	logic [IDX_W-1:0] rd_b_addr_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_slot;
		end
		rd_a_data_s1 <= mem[rd_a_addr];
		rd_b_data_s1 <= mem[rd_b_addr];
		rd_a_addr_s1 <= rd_a_addr;
		rd_b_addr_s1 <= rd_b_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q       <= '0;
			rd_a_written_s1 <= 1'b0;
			rd_b_written_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			rd_a_written_s1 <= written_q[rd_a_addr];
			rd_b_written_s1 <= written_q[rd_b_addr];
		end
	end

	always_comb begin
		if (rd_a_written_s1) begin
			rd_a_slot = rd_a_data_s1;
		end else begin
			rd_a_slot.machine = MACHINE_W'(rd_a_addr_s1);
			rd_a_slot.total   = '0;
		end
		if (rd_b_written_s1) begin
			rd_b_slot = rd_b_data_s1;
		end else begin
			rd_b_slot.machine = MACHINE_W'(rd_b_addr_s1);
			rd_b_slot.total   = '0;
		end
	end

`ifndef NO_ASSERTIONS
	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (int'(wr_addr) < NUM_MACHINES))
		else $error("heap write beyond last slot");
	a_written_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> written_q[$past(wr_addr)])
		else $error("written slot not marked");
	a_fresh_reads_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!rd_a_written_s1 |-> (rd_a_slot.total == '0))
		else $error("unwritten slot read nonzero total");
`endif

endmodule

@@ rtl/llma_sifter.sv @@
// ----------------------------------------------------------------------------
// llma_sifter
// request control, root update with saturation, and hole-based sift-down
// of the root over the heap memory
// ----------------------------------------------------------------------------
module llma_sifter #(
	parameter int NUM_MACHINES = llma_pkg::DEF_NUM_MACHINES,
	parameter int IDX_W        = $clog2(NUM_MACHINES)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [llma_pkg::LOAD_W-1:0]  job_size,
	output logic                         emit_valid,
	input  logic                         emit_ready,
	output llma_pkg::result_t            emit_res,
	output logic [IDX_W-1:0]             rd_a_addr,
	output logic [IDX_W-1:0]             rd_b_addr,
	input  llma_pkg::slot_t              rd_a_slot,
	input  llma_pkg::slot_t              rd_b_slot,
	output logic                         wr_en,
	output logic [IDX_W-1:0]             wr_addr,
	output llma_pkg::slot_t              wr_slot
);
	import llma_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ROOT = 5'b00010,
		ST_EMIT = 5'b00100,
		ST_READ = 5'b01000,
		ST_CMP  = 5'b10000
	} state_t;

	localparam logic [IDX_W+1:0] N_EXT = (IDX_W+2)'(NUM_MACHINES);

	state_t             state_q;
	logic [LOAD_W-1:0]  load_q;
	slot_t              held_q;
	logic [IDX_W-1:0]   pos_q;
	logic [IDX_W-1:0]   left_q;
	logic [IDX_W-1:0]   right_q;
	logic               has_right_q;

	logic [IDX_W+1:0]   left_ext;
	logic [IDX_W+1:0]   right_ext;
	logic [TOTAL_W:0]   sum_ext;
	logic               left_wins;
	logic               right_wins;
	logic [TOTAL_W-1:0] cur_min;

	assign in_stall   = (state_q != ST_IDLE);
	assign emit_valid = (state_q == ST_EMIT);
	assign emit_res.machine_number = held_q.machine[NUM_W-1:0];
	assign emit_res.machine_total  = held_q.total;

	assign left_ext  = {1'b0, pos_q, 1'b1};
	assign right_ext = {1'b0, pos_q, 1'b0} + (IDX_W+2)'(2);
	assign sum_ext   = {1'b0, rd_a_slot.total} + (TOTAL_W+1)'(load_q);

	// the parent is the held root; a tie with the parent keeps the parent, and a tie between children picks the left one
	assign left_wins  = held_q.total > rd_a_slot.total;
	assign cur_min    = left_wins ? rd_a_slot.total : held_q.total;
	assign right_wins = has_right_q && (cur_min > rd_b_slot.total);

	always_comb begin
		rd_a_addr = '0;
		rd_b_addr = '0;
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_slot   = held_q;
		case (state_q)
			ST_READ: begin
				if (left_ext < N_EXT) begin
					rd_a_addr = left_ext[IDX_W-1:0];
					if (right_ext < N_EXT) begin
						rd_b_addr = right_ext[IDX_W-1:0];
					end
				end else begin
					wr_en = 1'b1;
				end
			end
			ST_CMP: begin
				wr_en = 1'b1;
				if (right_wins) begin
					wr_slot = rd_b_slot;
				end else if (left_wins) begin
					wr_slot = rd_a_slot;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				load_q <= job_size;
			end
			ST_ROOT: begin
				held_q.machine <= rd_a_slot.machine;
				held_q.total   <= sum_ext[TOTAL_W] ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];
			end
			ST_READ: begin
				left_q      <= left_ext[IDX_W-1:0];
				right_q     <= right_ext[IDX_W-1:0];
				has_right_q <= right_ext < N_EXT;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					pos_q   <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_ready) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (left_ext < N_EXT) begin
						state_q <= ST_CMP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_CMP: begin
					if (right_wins) begin
						pos_q   <= right_q;
						state_q <= ST_READ;
					end else if (left_wins) begin
						pos_q   <= left_q;
						state_q <= ST_READ;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_to_root: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_ROOT))
		else $error("accepted request did not start a root read");
	a_write_when_sifting: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_READ || state_q == ST_CMP))
		else $error("heap write outside sift");
	a_pos_descends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_READ) && $past(state_q == ST_CMP)) |-> (pos_q > $past(pos_q)))
		else $error("sift did not move down");
	a_root_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (pos_q == '0))
		else $error("sift not starting at root");
`endif

endmodule

@@ verif/tb_least_loaded_machine_assigner_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_least_loaded_machine_assigner_top
// checks the machine picked for each job and its new total against a heap
// predictor
// ----------------------------------------------------------------------------
// A short table of loads runs first: zero loads that tie at the root, full
// loads and mixed values. About 1200 random loads follow. Both sides idle at
// random. The result side holds off once for a long stretch, so the block
// fills up and stalls its input. The job side waits once partway through
// until every expected result has come back.
// ----------------------------------------------------------------------------
module tb_least_loaded_machine_assigner_top;
	import llma_pkg::*;

	localparam int MACHINES      = DEF_NUM_MACHINES;
	localparam int DIRECTED_JOBS = 20;
	localparam int RANDOM_JOBS   = 1200;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES  = 24;
	localparam int HOLD_AT       = 400;
	localparam int HOLD_CYCLES   = 300;
	localparam int PAUSE_AT      = 700;

	typedef struct packed {
		bit                 typed;
		logic [NUM_W-1:0]   machine_number;
		logic [TOTAL_W-1:0] machine_total;
		logic [LOAD_W-1:0]  load;
	} job_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [LOAD_W-1:0]  job_size;
	logic               out_valid;
	logic               out_stall;
	logic [NUM_W-1:0]   machine_number;
	logic [TOTAL_W-1:0] machine_total;

	// predictor's copy of the heap
	logic [MACHINE_W-1:0] heap_machine [MACHINES];
	logic [TOTAL_W-1:0]   heap_total [MACHINES];

	result_t pending_assignments [$];
	int      errors = 0;
	int      results_seen = 0;
	int      cycle_count = 0;
	bit      sender_quiet = 1'b0;

	// typed rows: {typed, machine, total, load}
	job_row_t stim_table [DIRECTED_JOBS] = '{
		{1'b1, 4'd0, 32'h0000_0000, 16'h0000},	// zero load ties, machine 0 stays at root
		{1'b1, 4'd0, 32'h0000_0000, 16'h0000},
		{1'b1, 4'd0, 32'h0000_FFFF, 16'hFFFF},
		{1'b0, 4'd0, 32'h0000_0000, 16'h0001},
		{1'b0, 4'd0, 32'h0000_0000, 16'h8000},
		{1'b0, 4'd0, 32'h0000_0000, 16'h7FFF},
		{1'b0, 4'd0, 32'h0000_0000, 16'hFFFF},
		{1'b0, 4'd0, 32'h0000_0000, 16'hAAAA},
		{1'b0, 4'd0, 32'h0000_0000, 16'h5555},
		{1'b0, 4'd0, 32'h0000_0000, 16'h0000},
		{1'b0, 4'd0, 32'h0000_0000, 16'hFFFE},
		{1'b0, 4'd0, 32'h0000_0000, 16'h0100},
		{1'b0, 4'd0, 32'h0000_0000, 16'h00FF},
		{1'b0, 4'd0, 32'h0000_0000, 16'h0001},
		{1'b0, 4'd0, 32'h0000_0000, 16'h0001},
		{1'b0, 4'd0, 32'h0000_0000, 16'hFFFF},
		{1'b0, 4'd0, 32'h0000_0000, 16'hFFFF},
		{1'b0, 4'd0, 32'h0000_0000, 16'h0002},
		{1'b0, 4'd0, 32'h0000_0000, 16'h0000},
		{1'b0, 4'd0, 32'h0000_0000, 16'hFFFF}
	};

	least_loaded_machine_assigner_top #(
		.NUM_MACHINES(MACHINES)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.job_size       (job_size),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.machine_number (machine_number),
		.machine_total  (machine_total)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// give the job to the root machine, clamp its total, then sift the root down
	task automatic assign_to_least_loaded(input logic [LOAD_W-1:0] load, output result_t res);
		logic [TOTAL_W:0]     sum;
		logic [MACHINE_W-1:0] m;
		logic [TOTAL_W-1:0]   t;
		int                   pos;
		int                   left;
		int                   best;
		bit                   sifting;
		sum = {1'b0, heap_total[0]} + (TOTAL_W+1)'(load);
		heap_total[0] = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
		res.machine_number = heap_machine[0][NUM_W-1:0];
		res.machine_total = heap_total[0];
		pos = 0;
		sifting = 1'b1;
		while (sifting) begin
			left = 2 * pos + 1;
			best = pos;
			// strictly smaller only, so ties leave the upper slot in place
			if (left < MACHINES && heap_total[pos] > heap_total[left])
				best = left;
			if (left + 1 < MACHINES && heap_total[best] > heap_total[left + 1])
				best = left + 1;
			if (best == pos) begin
				sifting = 1'b0;
			end else begin
				m = heap_machine[pos];
				t = heap_total[pos];
				heap_machine[pos] = heap_machine[best];
				heap_total[pos] = heap_total[best];
				heap_machine[best] = m;
				heap_total[best] = t;
				pos = best;
			end
		end
	endtask

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [LOAD_W-1:0] pick_load();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return '1;
		// small loads make ties common
		if (r < 45)
			return LOAD_W'($urandom_range(0, 15));
		return LOAD_W'($urandom_range(0, 65535));
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic offer_job(input job_row_t row);
		result_t res;
		int      gap;
		gap = sender_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		job_size = row.load;
		do @(posedge clk); while (in_stall);
		assign_to_least_loaded(row.load, res);
		if (row.typed) begin
			res.machine_number = row.machine_number;
			res.machine_total = row.machine_total;
		end
		pending_assignments.push_back(res);
		@(negedge clk);
	endtask

	initial begin
		job_row_t row;
		in_valid = 1'b0;
		job_size = '0;
		arst_n = 1'b0;
		for (int k = 0; k < MACHINES; k++) begin
			heap_machine[k] = MACHINE_W'(k);
			heap_total[k] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (stim_table[i])
			offer_job(stim_table[i]);

		for (int n = 0; n < RANDOM_JOBS; n++) begin
			sender_quiet = ((n / 150) % 3) == 1;
			if (n == PAUSE_AT) begin
				in_valid = 1'b0;
				while (pending_assignments.size() != 0)
					@(posedge clk);
				@(negedge clk);
			end
			row = '0;
			row.load = pick_load();
			offer_job(row);
		end

		in_valid = 1'b0;
		while (pending_assignments.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// result side back-pressure
	initial begin
		int stall_left;
		int free_left;
		bit hold_done;
		stall_left = 0;
		free_left = 0;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else if (free_left > 0 || ((results_seen / 200) % 3) == 2) begin
				out_stall = 1'b0;
				if (free_left > 0)
					free_left--;
			end else begin
				stall_left = pick_gap();
				free_left = $urandom_range(1, 8);
				out_stall = stall_left > 0;
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_assignments.size() == 0) begin
				$display("%0t: result with no request waiting, machine %0d total %0d",
					$time, machine_number, machine_total);
				errors++;
			end else begin
				want = pending_assignments.pop_front();
				if (machine_number !== want.machine_number) begin
					$display("%0t: machine_number expected %0d, got %0d",
						$time, want.machine_number, machine_number);
					errors++;
				end
				if (machine_total !== want.machine_total) begin
					$display("%0t: machine_total expected %0d, got %0d",
						$time, want.machine_total, machine_total);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule

@@ files.f @@
rtl/llma_pkg.sv
rtl/llma_heap_mem.sv
rtl/llma_sifter.sv
rtl/least_loaded_machine_assigner_top.sv
verif/tb_least_loaded_machine_assigner_top.sv
